>>> sv/clwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the completion low-water mark tracker.
// Used by clwm_front, clwm_back and completion_low_water_mark.
package clwm_pkg;

    localparam int ID_W       = 64;
    // WINDOW is a power of two: the slot of an id is its low SLOT_W bits
    localparam int WINDOW     = 64;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam logic [ID_W-1:0] HALF_RANGE = {1'b0, {(ID_W-1){1'b1}}};

    localparam int QDEPTH     = 2;
    localparam int QA_W       = $clog2(QDEPTH);
    localparam int QC_W       = $clog2(QDEPTH + 1);

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_FINISH   = 1'b1
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EPOCH,
        ST_APPLY,
        ST_WALK
    } t_bstate;

endpackage

>>> sv/clwm_front.sv
`timescale 1ns / 1ps
// Front end: takes command words, decodes the function and queues them.
// Depends on clwm_pkg.
module clwm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_func,
    input  logic [clwm_pkg::ID_W-1:0] i_task_id,
    output clwm_pkg::t_qhead          o_head,
    input  logic                      i_pop
);

    clwm_pkg::t_item             r_q [clwm_pkg::QDEPTH];
    logic [clwm_pkg::QA_W-1:0]   r_wp, n_wp;
    logic [clwm_pkg::QA_W-1:0]   r_rp, n_rp;
    logic [clwm_pkg::QC_W-1:0]   r_cnt, n_cnt;
    logic                        push;
    logic                        pop;
    clwm_pkg::t_item             in_item;

    function automatic logic [clwm_pkg::QC_W-1:0] QC_ONE(input logic b);
        QC_ONE = {{(clwm_pkg::QC_W-1){1'b0}}, b};
    endfunction

    assign busy = (r_cnt == clwm_pkg::QC_W'(clwm_pkg::QDEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != '0);

    always_comb begin
        in_item.op = i_func ? clwm_pkg::OP_FINISH : clwm_pkg::OP_REGISTER;
        in_item.id = i_task_id;
    end

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QC_ONE(push) - QC_ONE(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

>>> sv/clwm_back.sv
`timescale 1ns / 1ps
// Back end: applies register and finish words to the slot window and walks
// the low-water mark. Depends on clwm_pkg.
module clwm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  clwm_pkg::t_qhead          i_head,
    output logic                      o_pop,
    output logic                      o_done,
    output logic                      o_accepted,
    output logic                      o_mark_moved,
    output logic [clwm_pkg::ID_W-1:0] o_low_mark
);

    clwm_pkg::t_bstate                r_state, n_state;
    clwm_pkg::t_op                    r_op, n_op;
    logic [clwm_pkg::ID_W-1:0]        r_id, n_id;
    logic [clwm_pkg::ID_W-1:0]        r_mark, n_mark;
    logic [clwm_pkg::WINDOW-1:0]      r_act, n_act;
    logic [clwm_pkg::WINDOW-1:0]      r_fin, n_fin;
    logic [clwm_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_acc, n_acc;
    logic                             r_moved, n_moved;
    logic                             r_done, n_done;

    logic [clwm_pkg::ID_W-1:0]        offset;
    logic                             in_win;
    logic [clwm_pkg::SLOT_W-1:0]      id_slot;
    logic [clwm_pkg::SLOT_W-1:0]      mark_slot;

    assign offset    = r_id - r_mark;
    assign in_win    = offset < clwm_pkg::ID_W'(clwm_pkg::WINDOW);
    assign id_slot   = r_id[clwm_pkg::SLOT_W-1:0];
    assign mark_slot = r_mark[clwm_pkg::SLOT_W-1:0];

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_id    = r_id;
        n_mark  = r_mark;
        n_act   = r_act;
        n_fin   = r_fin;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_moved = r_moved;
        n_done  = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            clwm_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_head.item.op;
                    n_id    = i_head.item.id;
                    n_state = (i_head.item.op == clwm_pkg::OP_FINISH)
                              ? clwm_pkg::ST_EPOCH : clwm_pkg::ST_APPLY;
                end
            end
            clwm_pkg::ST_EPOCH: begin
                // ids wrapped: start a new epoch
                if ((r_id < r_mark) && (r_mark > clwm_pkg::HALF_RANGE)) begin
                    n_mark = '0;
                end
                n_state = clwm_pkg::ST_APPLY;
            end
            clwm_pkg::ST_APPLY: begin
                n_acc   = 1'b0;
                n_moved = 1'b0;
                n_done  = 1'b1;
                n_state = clwm_pkg::ST_IDLE;
                if (r_op == clwm_pkg::OP_REGISTER) begin
                    if (in_win && !r_act[id_slot]) begin
                        n_act[id_slot] = 1'b1;
                        n_fin[id_slot] = 1'b0;
                        n_acc          = 1'b1;
                    end
                end else if (in_win && r_act[id_slot]) begin
                    n_fin[id_slot] = 1'b1;
                    n_acc          = 1'b1;
                    if (r_id == r_mark) begin
                        // free the head slot, then walk the finished run
                        n_act[id_slot] = 1'b0;
                        n_fin[id_slot] = 1'b0;
                        n_mark         = r_id + 1'b1;
                        n_moved        = 1'b1;
                        n_cnt          = clwm_pkg::CNT_W'(1);
                        n_done         = 1'b0;
                        n_state        = clwm_pkg::ST_WALK;
                    end
                end
            end
            clwm_pkg::ST_WALK: begin
                if ((r_cnt < clwm_pkg::CNT_W'(clwm_pkg::WINDOW))
                    && r_act[mark_slot] && r_fin[mark_slot]) begin
                    n_act[mark_slot] = 1'b0;
                    n_fin[mark_slot] = 1'b0;
                    n_mark           = r_mark + 1'b1;
                    n_cnt            = r_cnt + 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = clwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = clwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clwm_pkg::ST_IDLE;
            r_mark  <= '0;
            r_act   <= '0;
            r_fin   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mark  <= n_mark;
            r_act   <= n_act;
            r_fin   <= n_fin;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_id    <= n_id;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_moved <= n_moved;
    end

    assign o_done       = r_done;
    assign o_accepted   = r_acc;
    assign o_mark_moved = r_moved;
    assign o_low_mark   = r_mark;

`ifndef SYNTH
    a_moved_implies_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_moved || r_acc))
        else $error("mark moved on a rejected word");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clwm_pkg::ST_WALK) |->
            (r_cnt <= clwm_pkg::CNT_W'(clwm_pkg::WINDOW)) && r_moved)
        else $error("walk ran past the window");

    a_fin_needs_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clwm_pkg::ST_WALK) && r_act[mark_slot] && r_fin[mark_slot]
            && (r_cnt < clwm_pkg::CNT_W'(clwm_pkg::WINDOW))
            |=> (r_mark == $past(r_mark) + 1'b1))
        else $error("walk did not advance the mark");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == clwm_pkg::ST_IDLE) && i_head.valid)
        else $error("pop outside idle");
`endif

endmodule

>>> sv/completion_low_water_mark.sv
`timescale 1ns / 1ps
// Top level of the completion low-water mark tracker.
// Depends on clwm_pkg, clwm_front and clwm_back.
//
// Command channel: a word (i_func, i_task_id) is taken at a rising edge with
// start high and busy low. i_func 0 registers a task id, 1 reports it done.
// Words go into a two-entry queue; busy is high while that queue is full.
// Result channel: o_done is high for exactly one cycle per word, together
// with o_accepted, o_mark_moved and o_low_mark. The receiver cannot stall;
// results leave in the order the words came in.
// An accepted word is queued; the back end pops it in ST_IDLE. A register
// word then passes ST_APPLY; a finish word passes ST_EPOCH before ST_APPLY,
// and a finish that moves the mark then walks in ST_WALK, freeing the further
// finished slots (at most WINDOW - 1) before o_done. The back end handles one
// word at a time, taking no new word before o_done for the last, and frees
// one slot per cycle of the walk.
// Reset (synchronous, active low): mark goes to zero, all slots clear, the
// queue empties; the block takes words in the first cycle after reset.
module completion_low_water_mark (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_func,
    input  logic [clwm_pkg::ID_W-1:0] i_task_id,
    output logic                      o_done,
    output logic                      o_accepted,
    output logic                      o_mark_moved,
    output logic [clwm_pkg::ID_W-1:0] o_low_mark
);

    clwm_pkg::t_qhead head;
    logic             pop;

    clwm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_func    (i_func),
        .i_task_id (i_task_id),
        .o_head    (head),
        .i_pop     (pop)
    );

    clwm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_accepted   (o_accepted),
        .o_mark_moved (o_mark_moved),
        .o_low_mark   (o_low_mark)
    );

endmodule
